// File: hw/rtl/bcs_pkg.sv
// Shared types, codes and default constants for the bucket count and scatter block.
package bcs_pkg;

   localparam int unsigned DEF_MAX_BUCKETS = 64;
   localparam int unsigned DEF_MAX_ITEMS   = 65536;
   localparam int unsigned ACTIVE_W        = 7;
   localparam int unsigned BUCKET_W        = 6;
   localparam int unsigned VALUE_W         = 17;
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 7'd64;

   typedef enum logic [1:0] {
      FUNC_COUNT  = 2'd0,
      FUNC_PLACE  = 2'd1,
      FUNC_REWIND = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      func_type            func;
      logic [BUCKET_W-1:0] bucket;
   } req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      status_type         status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_WALK,
      S_FETCH,
      S_RESULT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic walk_init;
      logic walk_run;
      logic fetch;
      logic commit;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      func_type func;
      logic     range_bad;
      logic     starts_ready;
      logic     walk_done;
      logic     out_free;
   } sts_type;

endpackage

// File: hw/rtl/bcs_ctrl.sv
// Sequencing state machine for the bucket count and scatter block.
module bcs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  bcs_pkg::sts_type sts,
   output bcs_pkg::cmd_type cmd
);
   import bcs_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            if (sts.range_bad || sts.func == FUNC_CLEAR) begin
               state_in = S_RESULT;
            end else if (sts.func == FUNC_COUNT) begin
               state_in = S_FETCH;
            end else if (sts.func == FUNC_PLACE && sts.starts_ready) begin
               state_in = S_FETCH;
            end else begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (sts.walk_done) begin
               state_in = (sts.func == FUNC_PLACE) ? S_FETCH : S_RESULT;
            end
         end
         S_FETCH: begin
            state_in = S_RESULT;
         end
         S_RESULT: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         S_DECODE: begin
            cmd.walk_init = !sts.range_bad &&
                            ((sts.func == FUNC_PLACE && !sts.starts_ready) ||
                             sts.func == FUNC_REWIND);
         end
         S_WALK: begin
            cmd.walk_run = 1'b1;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
         end
         S_RESULT: begin
            cmd.commit = sts.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// File: hw/rtl/bcs_datapath.sv
// Bucket memories, prefix walk, result logic and output register.
module bcs_datapath #(
   parameter int unsigned MAX_BUCKETS = bcs_pkg::DEF_MAX_BUCKETS,
   parameter int unsigned MAX_ITEMS   = bcs_pkg::DEF_MAX_ITEMS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bcs_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bcs_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [bcs_pkg::ACTIVE_W-1:0]  csr_wr_data,
   input  bcs_pkg::cmd_type              cmd,
   output bcs_pkg::sts_type              sts
);
   import bcs_pkg::*;

   localparam int BW  = $clog2(MAX_BUCKETS);
   localparam int WCW = $clog2(MAX_BUCKETS + 1);
   localparam int CW  = $clog2(MAX_ITEMS + 1);
   localparam int LW  = (WCW > ACTIVE_W) ? WCW : ACTIVE_W;
   localparam int XW  = (CW > VALUE_W) ? CW : VALUE_W;

   req_type              req_ff;
   logic [ACTIVE_W-1:0]  active_ff;
   logic                 ready_ff;
   logic [CW-1:0]        total_ff;
   logic [MAX_BUCKETS-1:0] vld_ff;
   logic [CW-1:0]        cnt_mem [MAX_BUCKETS];
   logic [CW-1:0]        end_mem [MAX_BUCKETS];
   logic [CW-1:0]        nxt_mem [MAX_BUCKETS];
   logic [CW-1:0]        cnt_rd_ff;
   logic                 cvld_rd_ff;
   logic [CW-1:0]        end_rd_ff;
   logic [CW-1:0]        nxt_rd_ff;
   logic [WCW-1:0]       idx_ff;
   logic                 pend_ff;
   logic [BW-1:0]        pend_addr_ff;
   logic [CW-1:0]        run_ff;
   rsp_type              rsp_ff;
   logic                 rsp_valid_ff;

   logic [LW-1:0]        active_ext;
   logic [WCW-1:0]       live;
   logic [LW-1:0]        bucket_ext;
   logic [BW-1:0]        req_addr;
   logic                 range_bad;
   logic                 walk_issue;
   logic                 walk_done;
   logic                 walk_wr;
   logic                 cnt_rd_en;
   logic [BW-1:0]        cnt_rd_addr;
   logic [CW-1:0]        cnt_val;
   logic [CW-1:0]        cnt_inc;
   logic [CW-1:0]        run_sum;
   logic                 overflow;
   logic                 full;
   logic                 count_ok;
   logic                 place_ok;
   logic                 clear_hit;
   logic [CW-1:0]        result_val;
   logic [XW-1:0]        result_ext;
   rsp_type              rsp_in;
   logic                 out_free;

   assign active_ext = LW'(active_ff);
   assign live       = (active_ext < LW'(MAX_BUCKETS)) ? active_ext[WCW-1:0]
                                                       : WCW'(MAX_BUCKETS);
   assign bucket_ext = LW'(req_ff.bucket);
   assign req_addr   = bucket_ext[BW-1:0];
   assign range_bad  = (req_ff.func == FUNC_COUNT || req_ff.func == FUNC_PLACE) &&
                       (bucket_ext >= LW'(live));

   assign walk_issue  = cmd.walk_run && (idx_ff < live);
   assign walk_done   = (idx_ff == live) && !pend_ff;
   assign walk_wr     = cmd.walk_run && pend_ff;
   assign cnt_rd_en   = walk_issue || cmd.fetch;
   assign cnt_rd_addr = cmd.fetch ? req_addr : idx_ff[BW-1:0];

   // Entries never counted since the last clear read as zero
   assign cnt_val  = cvld_rd_ff ? cnt_rd_ff : '0;
   assign cnt_inc  = cnt_val + 1'b1;
   assign run_sum  = run_ff + cnt_val;
   assign overflow = total_ff >= CW'(MAX_ITEMS);
   assign full     = nxt_rd_ff >= end_rd_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      result_val    = '0;
      rsp_in.status = ST_OK;
      count_ok      = 1'b0;
      place_ok      = 1'b0;
      clear_hit     = 1'b0;
      unique case (req_ff.func)
         FUNC_COUNT: begin
            if (range_bad) begin
               rsp_in.status = ST_RANGE;
            end else if (overflow) begin
               result_val    = cnt_val;
               rsp_in.status = ST_OVERFLOW;
            end else begin
               result_val = cnt_inc;
               count_ok   = 1'b1;
            end
         end
         FUNC_PLACE: begin
            if (range_bad) begin
               rsp_in.status = ST_RANGE;
            end else if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               result_val = nxt_rd_ff;
               place_ok   = 1'b1;
            end
         end
         FUNC_REWIND: begin
            result_val = total_ff;
         end
         FUNC_CLEAR: begin
            result_val = total_ff;
            clear_hit  = 1'b1;
         end
      endcase
      result_ext   = XW'(result_val);
      rsp_in.value = result_ext[VALUE_W-1:0];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= ACTIVE_RESET;
         ready_ff     <= 1'b0;
         total_ff     <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            active_ff <= csr_wr_data;
            ready_ff  <= 1'b0;
         end
         if (cmd.walk_run && walk_done) ready_ff <= 1'b1;
         if (cmd.commit && count_ok) begin
            total_ff         <= total_ff + 1'b1;
            vld_ff[req_addr] <= 1'b1;
            ready_ff         <= 1'b0;
         end
         if (cmd.commit && clear_hit) begin
            total_ff <= '0;
            vld_ff   <= '0;
            ready_ff <= 1'b0;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.walk_init) begin
            idx_ff  <= '0;
            pend_ff <= 1'b0;
         end else if (cmd.walk_run) begin
            if (walk_issue) idx_ff <= idx_ff + 1'b1;
            pend_ff <= walk_issue;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) req_ff <= req_data;
      if (cmd.walk_init) begin
         run_ff <= '0;
      end else if (walk_wr) begin
         run_ff <= run_sum;
      end
      if (cmd.walk_run) pend_addr_ff <= idx_ff[BW-1:0];
      if (cmd.commit) rsp_ff <= rsp_in;
   end

   // Count memory
   always_ff @(posedge clock) begin
      if (cmd.commit && count_ok) cnt_mem[req_addr] <= cnt_inc;
      if (cnt_rd_en) begin
         cnt_rd_ff  <= cnt_mem[cnt_rd_addr];
         cvld_rd_ff <= vld_ff[cnt_rd_addr];
      end
   end

   // Bucket end memory: start plus count, written by the walk
   always_ff @(posedge clock) begin
      if (walk_wr) end_mem[pend_addr_ff] <= run_sum;
      if (cmd.fetch) end_rd_ff <= end_mem[req_addr];
   end

   // Next free slot memory
   always_ff @(posedge clock) begin
      if (walk_wr) begin
         nxt_mem[pend_addr_ff] <= run_ff;
      end else if (cmd.commit && place_ok) begin
         nxt_mem[req_addr] <= nxt_rd_ff + 1'b1;
      end
      if (cmd.fetch) nxt_rd_ff <= nxt_mem[req_addr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;
   assign sts.func         = req_ff.func;
   assign sts.range_bad    = range_bad;
   assign sts.starts_ready = ready_ff;
   assign sts.walk_done    = walk_done;
   assign sts.out_free     = out_free;

endmodule

// File: hw/rtl/bucket_count_and_scatter.sv
// Top level of the bucket count and scatter engine: controller, datapath and checks.
//
//   Channel   Ports                                   Direction  Moves
//   request   req_valid, req_stall, req_data          in         func, bucket
//   response  rsp_valid, rsp_stall, rsp_data          out        value, status
//   csr       csr_wr_en, csr_wr_data                  in         active_buckets
//
// A count or a place with offsets already built goes from acceptance to the next
// acceptance through the steps accept, decode, memory fetch and result; the fetch
// step is there for the registered memory read. A clear or an out-of-range request
// skips the fetch.
// The first place after counting, after a clear or after a csr write, and every
// rewind, first walks the live buckets, min(active_buckets, MAX_BUCKETS) of them,
// with one count memory read per bucket feeding the running sum. A rewind has
// no fetch step.
// Reset is synchronous and active high; it empties the histogram at once through
// per-bucket valid bits, and sets active_buckets to 64.
// A finished response waits in the output register while rsp_stall is high; the
// next request is still accepted, and only its own result step waits.
module bucket_count_and_scatter #(
   parameter int unsigned MAX_BUCKETS = bcs_pkg::DEF_MAX_BUCKETS,
   parameter int unsigned MAX_ITEMS   = bcs_pkg::DEF_MAX_ITEMS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  bcs_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bcs_pkg::rsp_type              rsp_data,
   input  logic                          csr_wr_en,
   input  logic [bcs_pkg::ACTIVE_W-1:0]  csr_wr_data
);
   import bcs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequence each request: decode, optional prefix walk, optional fetch, result
   bcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Hold counts, bucket ends and next slots; build responses
   bcs_datapath #(
      .MAX_BUCKETS (MAX_BUCKETS),
      .MAX_ITEMS   (MAX_ITEMS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

   // Never overwrite a response that is still waiting
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || !rsp_stall))
      else $error("response committed over a stalled response");

   // A finished walk leaves the offsets marked as built
   a_walk_ready: assert property (@(posedge clock) disable iff (reset)
      (cmd.walk_run && sts.walk_done) |=> sts.starts_ready)
      else $error("prefix walk finished without marking offsets ready");

   // One request at a time: hold off after acceptance
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second request accepted while one is in work");

   // Every commit shows up on the response channel
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("committed response not presented");

endmodule
